/* design/pspr_pkg.sv */
package pspr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CodeW     = 6;
  localparam int unsigned CarryW    = 4;
  localparam int unsigned GroupW    = 2;
  localparam int unsigned EndFrameW = 14;
  localparam int unsigned FrameW    = 13;

  // Result queue depth. A byte can produce two results, so the queue must
  // hold at least two entries.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Boundaries and offsets of the six-bit character map.
  localparam logic [CodeW-1:0] CodeLastUpper = 6'd26;
  localparam logic [CodeW-1:0] CodeLastLower = 6'd52;
  localparam logic [CodeW-1:0] CodeLastDigit = 6'd62;
  localparam logic [ByteW-1:0] OffUpper      = 8'd64;
  localparam logic [ByteW-1:0] OffLower      = 8'd70;
  localparam logic [ByteW-1:0] OffDigit      = 8'd5;
  localparam logic [ByteW-1:0] AsciiUnder    = 8'd95;

  // Group positions inside a three-byte, four-character group.
  localparam logic [GroupW-1:0] GrpFirst  = 2'd0;
  localparam logic [GroupW-1:0] GrpSecond = 2'd1;
  localparam logic [GroupW-1:0] GrpThird  = 2'd2;

  typedef enum logic [5:0] {
    PH_NAME_LEN = 6'b000001,
    PH_NAME_DAT = 6'b000010,
    PH_FILE_LEN = 6'b000100,
    PH_FILE_DAT = 6'b001000,
    PH_TRAIL_HI = 6'b010000,
    PH_TRAIL_LO = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_FILE    = 2'd1,
    KIND_SAME    = 2'd2,
    KIND_TRAILER = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                        kind;
    logic [ByteW-1:0]             char_code;
    logic signed [EndFrameW-1:0]  stop_frame;
    logic                         flag_motion;
    logic                         flag_no_hitlag;
    logic                         flag_spare;
    logic                         last_of_run;
  } result_t;

  function automatic logic [ByteW-1:0] map_code(logic [CodeW-1:0] code);
    logic [ByteW-1:0] wide;
    wide = {{(ByteW - CodeW){1'b0}}, code};
    if (code == '0) begin
      return '0;
    end else if (code <= CodeLastUpper) begin
      return wide + OffUpper;
    end else if (code <= CodeLastLower) begin
      return wide + OffLower;
    end else if (code <= CodeLastDigit) begin
      return wide - OffDigit;
    end
    return AsciiUnder;
  endfunction

endpackage

/* design/pspr_in_if.sv */
interface pspr_in_if;
  logic                        valid;
  logic                        ready;
  logic [pspr_pkg::ByteW-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* design/pspr_out_if.sv */
interface pspr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              kind;
  logic [pspr_pkg::ByteW-1:0]              char_code;
  logic signed [pspr_pkg::EndFrameW-1:0]   stop_frame;
  logic                                    flag_motion;
  logic                                    flag_no_hitlag;
  logic                                    flag_spare;
  logic                                    last_of_run;

  modport source (
    output valid, output kind, output char_code, output stop_frame,
    output flag_motion, output flag_no_hitlag, output flag_spare,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input char_code, input stop_frame,
    input flag_motion, input flag_no_hitlag, input flag_spare,
    input last_of_run, output ready
  );
endinterface

/* design/packed_six_bit_record_parser_top.sv */
// Record stream parser for six-bit packed names. Each accepted input beat is
// one raw byte of the stream: a name length byte, the packed name codes, a
// file-name length byte, the packed file-name codes and two trailer bytes.
// Codes are packed big-endian, three bytes to four characters, and a length of
// L gives exactly L characters. A byte yields zero, one or two result beats:
// decoded ASCII characters of the name (kind 0) and file name (kind 1), a single
// kind 2 beat when the file-name length is zero (the file name is the name),
// and a kind 3 trailer beat carrying the 13-bit end frame (all ones reads as
// -1) and three flag bits. last_of_run marks the final result of each byte.
// Length bytes and the first trailer byte produce nothing, except the kind 2
// case. Throughput is one input byte per clock as long as each byte yields at
// most one result and the sink takes one beat per clock; the output side moves
// one result per clock while the sink is ready, so the second character of a
// byte that completes a group waits in a four-entry result queue. Each byte
// passes the input register, then the decode step that writes the queue and
// stalls while the queue has fewer than two free entries. When report_frame
// is clear the trailer beat carries zero for end frame and flags. The register
// resets to one and should only be written while the block is idle.
module packed_six_bit_record_parser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  pspr_in_if.sink           in_i,
  pspr_out_if.source        out_o
);

  localparam int unsigned ByteW  = pspr_pkg::ByteW;
  localparam int unsigned QPtrW  = pspr_pkg::QPtrW;
  localparam int unsigned QCntW  = pspr_pkg::QCntW;

  // Configuration register.
  logic report_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_frame_q <= 1'b1;
    end else if (cfg_we_i) begin
      report_frame_q <= cfg_wdata_i;
    end
  end

  // Input register stage.
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             proc;

  // The queue needs two free entries before a byte is decoded, since a byte
  // may produce two results.
  logic [QCntW-1:0] q_cnt_q;
  logic             q_room;

  assign q_room   = (q_cnt_q <= QCntW'(pspr_pkg::QDepth - 2));
  assign proc     = in_vld_q && q_room;
  assign in_i.ready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  // Parser state.
  pspr_pkg::phase_e                 phase_q, phase_d;
  logic [ByteW-1:0]                 chars_left_q, chars_left_d;
  logic [pspr_pkg::GroupW-1:0]      group_pos_q, group_pos_d;
  logic [pspr_pkg::CarryW-1:0]      carry_q, carry_d;
  logic [ByteW-1:0]                 frame_high_q, frame_high_d;

  // Decode of the byte in the input register.
  pspr_pkg::result_t                res0, res1;
  logic                             push0, push1;
  pspr_pkg::kind_e                  chr_kind;
  logic [pspr_pkg::CodeW-1:0]       code0;
  logic [ByteW-1:0]                 left_a, left_b;
  logic [pspr_pkg::FrameW-1:0]      frame;
  logic signed [pspr_pkg::EndFrameW-1:0] frame_out;

  assign frame = {frame_high_q, in_byte_q[ByteW-1:3]};
  assign frame_out = (&frame) ? '1 : $signed({1'b0, frame});

  always_comb begin
    phase_d      = phase_q;
    chars_left_d = chars_left_q;
    group_pos_d  = group_pos_q;
    carry_d      = carry_q;
    frame_high_d = frame_high_q;
    push0        = 1'b0;
    push1        = 1'b0;
    res0         = '0;
    res1         = '0;
    chr_kind     = (phase_q == pspr_pkg::PH_NAME_DAT) ? pspr_pkg::KIND_NAME
                                                      : pspr_pkg::KIND_FILE;
    code0        = '0;
    left_a       = chars_left_q;
    left_b       = chars_left_q;

    unique case (phase_q)
      pspr_pkg::PH_NAME_DAT,
      pspr_pkg::PH_FILE_DAT: begin
        unique case (group_pos_q)
          pspr_pkg::GrpFirst: begin
            code0       = in_byte_q[7:2];
            carry_d     = {2'b00, in_byte_q[1:0]};
            group_pos_d = pspr_pkg::GrpSecond;
          end
          pspr_pkg::GrpSecond: begin
            code0       = {carry_q[1:0], in_byte_q[7:4]};
            carry_d     = in_byte_q[3:0];
            group_pos_d = pspr_pkg::GrpThird;
          end
          default: begin
            code0       = {carry_q, in_byte_q[7:6]};
            carry_d     = '0;
            group_pos_d = pspr_pkg::GrpFirst;
          end
        endcase
        push0 = (chars_left_q != '0);
        left_a = chars_left_q - ByteW'(push0);
        push1 = (group_pos_q != pspr_pkg::GrpFirst) &&
                (group_pos_q != pspr_pkg::GrpSecond) && (left_a != '0);
        left_b = left_a - ByteW'(push1);
        res0.kind      = chr_kind;
        res0.char_code = pspr_pkg::map_code(code0);
        res0.last_of_run = !push1;
        res1.kind      = chr_kind;
        res1.char_code = pspr_pkg::map_code(in_byte_q[5:0]);
        res1.last_of_run = 1'b1;
        chars_left_d = left_b;
        if (left_b == '0) begin
          phase_d     = (phase_q == pspr_pkg::PH_NAME_DAT) ? pspr_pkg::PH_FILE_LEN
                                                           : pspr_pkg::PH_TRAIL_HI;
          group_pos_d = pspr_pkg::GrpFirst;
          carry_d     = '0;
        end
      end
      pspr_pkg::PH_FILE_LEN: begin
        group_pos_d = pspr_pkg::GrpFirst;
        carry_d     = '0;
        if (in_byte_q == '0) begin
          push0            = 1'b1;
          res0.kind        = pspr_pkg::KIND_SAME;
          res0.last_of_run = 1'b1;
          phase_d          = pspr_pkg::PH_TRAIL_HI;
        end else begin
          chars_left_d = in_byte_q;
          phase_d      = pspr_pkg::PH_FILE_DAT;
        end
      end
      pspr_pkg::PH_TRAIL_HI: begin
        frame_high_d = in_byte_q;
        phase_d      = pspr_pkg::PH_TRAIL_LO;
      end
      pspr_pkg::PH_TRAIL_LO: begin
        push0            = 1'b1;
        res0.kind        = pspr_pkg::KIND_TRAILER;
        res0.last_of_run = 1'b1;
        if (report_frame_q) begin
          res0.stop_frame     = frame_out;
          res0.flag_motion    = in_byte_q[0];
          res0.flag_no_hitlag = in_byte_q[1];
          res0.flag_spare     = in_byte_q[2];
        end
        phase_d = pspr_pkg::PH_NAME_LEN;
      end
      default: begin
        // Expecting the name length; an empty name skips to the file name.
        group_pos_d = pspr_pkg::GrpFirst;
        carry_d     = '0;
        if (in_byte_q == '0) begin
          phase_d = pspr_pkg::PH_FILE_LEN;
        end else begin
          chars_left_d = in_byte_q;
          phase_d      = pspr_pkg::PH_NAME_DAT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= pspr_pkg::PH_NAME_LEN;
      chars_left_q <= '0;
      group_pos_q  <= pspr_pkg::GrpFirst;
      carry_q      <= '0;
      frame_high_q <= '0;
    end else if (proc) begin
      phase_q      <= phase_d;
      chars_left_q <= chars_left_d;
      group_pos_q  <= group_pos_d;
      carry_q      <= carry_d;
      frame_high_q <= frame_high_d;
    end
  end

  // Result queue. Up to two entries are written per cycle, at most one is read.
  pspr_pkg::result_t q_mem [pspr_pkg::QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic              do_push0, do_push1, do_pop;
  logic [QPtrW-1:0]  wr_ptr_next;

  assign do_push0    = proc && push0;
  assign do_push1    = proc && push1;
  assign do_pop      = out_o.valid && out_o.ready;
  assign wr_ptr_next = wr_ptr_q + QPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (do_push0) begin
      q_mem[wr_ptr_q] <= res0;
    end
    if (do_push1) begin
      q_mem[wr_ptr_next] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(do_push0) + QPtrW'(do_push1);
      rd_ptr_q <= rd_ptr_q + QPtrW'(do_pop);
      q_cnt_q  <= q_cnt_q + QCntW'(do_push0) + QCntW'(do_push1) - QCntW'(do_pop);
    end
  end

  pspr_pkg::result_t head;
  assign head = q_mem[rd_ptr_q];

  assign out_o.valid          = (q_cnt_q != '0);
  assign out_o.kind           = head.kind;
  assign out_o.char_code      = head.char_code;
  assign out_o.stop_frame     = head.stop_frame;
  assign out_o.flag_motion    = head.flag_motion;
  assign out_o.flag_no_hitlag = head.flag_no_hitlag;
  assign out_o.flag_spare     = head.flag_spare;
  assign out_o.last_of_run    = head.last_of_run;

`ifndef ASSERT_OFF
  // The queue never holds more than its depth.
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(pspr_pkg::QDepth))
    else $error("result queue overflow");

  // A second result only ever follows a first one from the same byte.
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push1 |-> do_push0)
    else $error("second result without first");

  // While in a data phase there is always at least one character to go.
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == pspr_pkg::PH_NAME_DAT || phase_q == pspr_pkg::PH_FILE_DAT)
      |-> chars_left_q != '0)
    else $error("data phase with no characters left");

  // The low trailer byte always closes the record.
  a_trailer_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && phase_q == pspr_pkg::PH_TRAIL_LO) |=> phase_q == pspr_pkg::PH_NAME_LEN)
    else $error("record did not close after trailer");
`endif

endmodule

/* verif/tb.sv */
module tb;

  // Longest run of cycles in which no beat moves on either side before the
  // run is declared hung. A correct run never gets near it: the random waits
  // of the sender and the receiver, the block's own pipeline and the hold-off
  // of a register write are all far shorter.
  localparam int unsigned StallLimit = 1000;

  // Number of mismatch lines printed before the report task only counts.
  localparam int unsigned ReportCap = 40;

  // Random bytes sent per register setting, and the number of settings.
  localparam int unsigned PhaseBytes = 220;
  localparam int unsigned PhaseCount = 5;

  // One row of the directed table. fixed is -1 when the expected results
  // come from the predictor, 0 when the byte must give no result, and 1 when
  // it must give exactly the result typed into want.
  typedef struct {
    logic [pspr_pkg::ByteW-1:0] b;
    int                         fixed;
    pspr_pkg::result_t          want;
  } stim_row_t;

  localparam pspr_pkg::result_t NoResult = '0;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  pspr_in_if  in_bus ();
  pspr_out_if out_bus ();

  packed_six_bit_record_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus.sink),
    .out_o       (out_bus.source)
  );

  // Predictor state: our own copy of where the parser stands in the record,
  // plus the one configuration bit.
  pspr_pkg::phase_e             rec_phase;
  logic [pspr_pkg::ByteW-1:0]   chars_to_go;
  logic [pspr_pkg::GroupW-1:0]  slot;
  logic [pspr_pkg::CarryW-1:0]  held_bits;
  logic [pspr_pkg::ByteW-1:0]   frame_msbs;
  logic                         frame_on;

  // Results worked out for the byte being accepted, and the store of results
  // still owed by the block, oldest first.
  pspr_pkg::result_t fresh_results[$];
  pspr_pkg::result_t owed_results[$];

  int unsigned bytes_taken;
  int unsigned results_taken;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // Set by the sender together with each byte; the monitor reads them when
  // that byte is accepted.
  int                fixed_count;
  pspr_pkg::result_t fixed_want;

  // When set, the side in question does not idle between beats.
  bit sender_calm;
  bit sink_calm;

  stim_row_t directed [24];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < ReportCap) begin
      $display("MISMATCH at result %0d: %s", results_taken, what);
    end
    mismatches++;
  endtask

  // Emit one decoded character while the current string still owes any. The
  // six-bit code maps to NUL, then A-Z, a-z, 0-9 and finally underscore.
  function automatic void take_char(input pspr_pkg::kind_e k,
                                    input logic [pspr_pkg::CodeW-1:0] code);
    pspr_pkg::result_t r;
    if (chars_to_go == '0) return;
    r = '0;
    r.kind = k;
    if (code == 6'd0) begin
      r.char_code = 8'h00;
    end else if (code < 6'd27) begin
      r.char_code = 8'h41 + 8'(code) - 8'd1;
    end else if (code < 6'd53) begin
      r.char_code = 8'h61 + 8'(code) - 8'd27;
    end else if (code < 6'd63) begin
      r.char_code = 8'h30 + 8'(code) - 8'd53;
    end else begin
      r.char_code = 8'h5F;
    end
    fresh_results = {fresh_results, r};
    chars_to_go = chars_to_go - 8'd1;
  endfunction

  // Advance the predictor by one stream byte and append the results it
  // causes to fresh_results. The final one carries last_of_run.
  function automatic void decode_byte(input logic [pspr_pkg::ByteW-1:0] b);
    pspr_pkg::kind_e   k;
    logic [12:0]       frame;
    pspr_pkg::result_t r;
    r = '0;
    k = (rec_phase == pspr_pkg::PH_NAME_DAT) ? pspr_pkg::KIND_NAME : pspr_pkg::KIND_FILE;
    case (rec_phase)
      pspr_pkg::PH_NAME_DAT, pspr_pkg::PH_FILE_DAT: begin
        // Codes are packed big-endian: four six-bit codes in three bytes.
        case (slot)
          pspr_pkg::GrpFirst: begin
            take_char(k, b[7:2]);
            held_bits = {2'b00, b[1:0]};
            slot = pspr_pkg::GrpSecond;
          end
          pspr_pkg::GrpSecond: begin
            take_char(k, {held_bits[1:0], b[7:4]});
            held_bits = b[3:0];
            slot = pspr_pkg::GrpThird;
          end
          default: begin
            take_char(k, {held_bits, b[7:6]});
            take_char(k, b[5:0]);
            held_bits = '0;
            slot = pspr_pkg::GrpFirst;
          end
        endcase
        if (chars_to_go == '0) begin
          rec_phase = (rec_phase == pspr_pkg::PH_NAME_DAT) ? pspr_pkg::PH_FILE_LEN
                                                           : pspr_pkg::PH_TRAIL_HI;
          slot = pspr_pkg::GrpFirst;
          held_bits = '0;
        end
      end
      pspr_pkg::PH_FILE_LEN: begin
        slot = pspr_pkg::GrpFirst;
        held_bits = '0;
        if (b == '0) begin
          // A zero file-name length means the file name repeats the name.
          r.kind = pspr_pkg::KIND_SAME;
          fresh_results = {fresh_results, r};
          rec_phase = pspr_pkg::PH_TRAIL_HI;
        end else begin
          chars_to_go = b;
          rec_phase = pspr_pkg::PH_FILE_DAT;
        end
      end
      pspr_pkg::PH_TRAIL_HI: begin
        frame_msbs = b;
        rec_phase = pspr_pkg::PH_TRAIL_LO;
      end
      pspr_pkg::PH_TRAIL_LO: begin
        frame = {frame_msbs, b[7:3]};
        r.kind = pspr_pkg::KIND_TRAILER;
        if (frame_on) begin
          // An end frame with all thirteen bits set reads as minus one.
          if (frame == 13'h1FFF) begin
            r.stop_frame = -14'sd1;
          end else begin
            r.stop_frame = {1'b0, frame};
          end
          r.flag_motion    = b[0];
          r.flag_no_hitlag = b[1];
          r.flag_spare     = b[2];
        end
        fresh_results = {fresh_results, r};
        rec_phase = pspr_pkg::PH_NAME_LEN;
      end
      default: begin
        slot = pspr_pkg::GrpFirst;
        held_bits = '0;
        if (b == '0) begin
          rec_phase = pspr_pkg::PH_FILE_LEN;
        end else begin
          chars_to_go = b;
          rec_phase = pspr_pkg::PH_NAME_DAT;
        end
      end
    endcase
    if (fresh_results.size() != 0) begin
      fresh_results[fresh_results.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  // Monitor for both channels. Each beat is taken at the rising edge at which
  // valid and ready are both high. Output beats are checked before input
  // beats are predicted; the result of an input beat passes through the input
  // register and the result queue first, so this order never loses a result.
  always @(posedge clk_i) begin
    bit                moved;
    pspr_pkg::result_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result beat with no result outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_bus.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_bus.kind, want.kind));
          if (out_bus.char_code !== want.char_code)
            report_mismatch($sformatf("char_code %0h, expected %0h",
                                      out_bus.char_code, want.char_code));
          if (out_bus.stop_frame !== want.stop_frame)
            report_mismatch($sformatf("stop_frame %0d, expected %0d",
                                      out_bus.stop_frame, want.stop_frame));
          if (out_bus.flag_motion !== want.flag_motion)
            report_mismatch($sformatf("flag_motion %b, expected %b",
                                      out_bus.flag_motion, want.flag_motion));
          if (out_bus.flag_no_hitlag !== want.flag_no_hitlag)
            report_mismatch($sformatf("flag_no_hitlag %b, expected %b",
                                      out_bus.flag_no_hitlag, want.flag_no_hitlag));
          if (out_bus.flag_spare !== want.flag_spare)
            report_mismatch($sformatf("flag_spare %b, expected %b",
                                      out_bus.flag_spare, want.flag_spare));
          if (out_bus.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      out_bus.last_of_run, want.last_of_run));
        end
        results_taken++;
        moved = 1'b1;
      end
      if (in_bus.valid && in_bus.ready) begin
        // The predictor always runs so that its state follows the stream;
        // a typed row then replaces what it worked out.
        fresh_results.delete();
        decode_byte(in_bus.in_byte);
        if (fixed_count >= 0) begin
          fresh_results.delete();
          if (fixed_count == 1) fresh_results = {fresh_results, fixed_want};
        end
        owed_results = {owed_results, fresh_results};
        bytes_taken++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: the run is hung once idle_cycles, counted while no beat moves, reaches StallLimit.
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("packed_six_bit_record_parser_top verification failed");
    $finish;
  end

  // Receiver: before every result beat it may hold ready low for a random stall
  // unless sink_calm is set, then keeps ready high until a beat has been taken.
  initial begin
    int unsigned stall;
    int unsigned seen;
    out_bus.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      seen = results_taken;
      do @(negedge clk_i); while (results_taken == seen);
    end
  end

  // Sender: unless sender_calm is set, waits a random gap, then offers one byte
  // and holds it until it is accepted. Called and returning at a falling edge.
  task automatic send_byte(input logic [pspr_pkg::ByteW-1:0] b, input int fixed = -1,
                           input pspr_pkg::result_t want = '0);
    int unsigned gap;
    int unsigned taken_at_start;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    fixed_count = fixed;
    fixed_want  = want;
    in_bus.in_byte <= b;
    in_bus.valid   <= 1'b1;
    taken_at_start = bytes_taken;
    do @(negedge clk_i); while (bytes_taken == taken_at_start);
  endtask

  // Stop sending and wait until every owed result has come back. Length
  // bytes leave nothing owed yet may still sit in the two-stage pipeline, so
  // the task lets them pass through it before anything else is done.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write report_frame while the block is idle.
  task automatic program_report(input bit on);
    drain();
    cfg_wdata <= on;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    frame_on = on;
  endtask

  // Mostly short strings, some of medium length, now and then the longest.
  // A file-name length may also be zero to exercise name reuse.
  function automatic logic [pspr_pkg::ByteW-1:0] pick_len(input bit allow_reuse);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll == 99) return 8'd255;
    if (roll >= 93) return 8'($urandom_range(13, 60));
    if (allow_reuse && roll < 20) return 8'd0;
    return 8'($urandom_range(0, 12));
  endfunction

  // Packed character data for a string of len characters: three bytes per
  // full group of four, one byte per character in the short final group.
  task automatic send_string(input logic [pspr_pkg::ByteW-1:0] len);
    repeat ((int'(len) / 4) * 3 + int'(len) % 4) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned                start;
    logic [pspr_pkg::ByteW-1:0] name_len;
    logic [pspr_pkg::ByteW-1:0] file_len;

    // Every input is known from time zero; the predictor starts in the
    // state the block takes on reset, with report_frame set.
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    rec_phase      = pspr_pkg::PH_NAME_LEN;
    chars_to_go    = '0;
    slot           = pspr_pkg::GrpFirst;
    held_bits      = '0;
    frame_msbs     = '0;
    frame_on       = 1'b1;
    fixed_count    = -1;
    fixed_want     = NoResult;
    sender_calm    = 1'b0;
    sink_calm      = 1'b0;
    bytes_taken    = 0;
    results_taken  = 0;
    mismatches     = 0;
    idle_cycles    = 0;

    // Directed records, sent with report_frame at its reset value.
    directed = '{
      // Empty name, then file name equal to the name, then an end frame of
      // all ones (minus one) with every flag set.
      '{8'h00,  0, NoResult},
      '{8'h00,  1, '{pspr_pkg::KIND_SAME, 8'h00, 14'sd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{8'hFF,  0, NoResult},
      '{8'hFF,  1, '{pspr_pkg::KIND_TRAILER, 8'h00, -14'sd1, 1'b1, 1'b1, 1'b1, 1'b1}},
      // Name of four characters, one full group: NUL, underscore, A and z.
      '{8'h04,  0, NoResult},
      '{8'h03, -1, NoResult},
      '{8'hF0, -1, NoResult},
      '{8'h74, -1, NoResult},
      // File name of five characters: 0, 9, Z, a in a full group, then a
      // short group of one whose byte is all ones.
      '{8'h05,  0, NoResult},
      '{8'hD7, -1, NoResult},
      '{8'hE6, -1, NoResult},
      '{8'h9B, -1, NoResult},
      '{8'hFF, -1, NoResult},
      // Trailer of all zeros.
      '{8'h00,  0, NoResult},
      '{8'h00,  1, '{pspr_pkg::KIND_TRAILER, 8'h00, 14'sd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      // Short final groups of two and three characters, mixed trailer.
      '{8'h02,  0, NoResult},
      '{8'h55, -1, NoResult},
      '{8'hAA, -1, NoResult},
      '{8'h03,  0, NoResult},
      '{8'h12, -1, NoResult},
      '{8'h34, -1, NoResult},
      '{8'h56, -1, NoResult},
      '{8'hAB,  0, NoResult},
      '{8'hCD, -1, NoResult}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_byte(directed[i].b, directed[i].fixed, directed[i].want);

    // Random records under alternating settings of report_frame. Each
    // setting change first lets the block run dry. One phase opens with the
    // longest name and another with the longest file name.
    for (int p = 0; p < PhaseCount; p++) begin
      program_report(p[0]);
      start = bytes_taken;
      while (bytes_taken - start < PhaseBytes) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        sink_calm   = ($urandom_range(0, 3) == 0);
        name_len = (p == 1 && bytes_taken == start) ? 8'd255 : pick_len(1'b0);
        file_len = (p == 3 && bytes_taken == start) ? 8'd255 : pick_len(1'b1);
        send_byte(name_len);
        send_string(name_len);
        send_byte(file_len);
        send_string(file_len);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        // Now and then a few stray bytes knock the stream off record
        // boundaries, and now and then the sender holds off until the
        // block has delivered everything it owes.
        if ($urandom_range(0, 19) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("packed_six_bit_record_parser_top verification clean");
    end else begin
      $display("packed_six_bit_record_parser_top verification failed");
    end
    $finish;
  end

endmodule
